// ===== rtl/mfi_pkg.sv =====
// mfi_pkg: shared constants, codes, controller states and the
// command/status bundles of the max-flow engine
// no dependencies
package mfi_pkg;

   // graph and word sizes
   localparam int MAX_NODES = 64;
   localparam int NODE_W    = 6;
   localparam int LABEL_W   = 7;
   localparam int CAP_W     = 16;
   localparam int RES_W     = 18;
   localparam int FLOW_W    = 22;
   localparam int RM_DEPTH  = MAX_NODES * MAX_NODES;
   localparam int RM_AW     = 2 * NODE_W;
   localparam int GAP_DEPTH = MAX_NODES + 2;
   localparam int GAP_AW    = 7;
   localparam int CMD_W     = 2;
   localparam int REQ_W     = 32;
   localparam int RSP_W     = 24;
   localparam int CSR_AW    = 2;
   localparam int CSR_DW    = 7;

   localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

   // request commands
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

   // configuration register indexes
   localparam logic [CSR_AW-1:0] CSR_NODE_COUNT = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_SOURCE     = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_SINK       = 2'd2;

   // controller phases, one-hot
   typedef enum logic [27:0] {
      ST_CLEAR   = 28'h0000001,
      ST_IDLE    = 28'h0000002,
      ST_INIT    = 28'h0000004,
      ST_BSEED   = 28'h0000008,
      ST_BHEAD   = 28'h0000010,
      ST_BQ      = 28'h0000020,
      ST_BSCAN   = 28'h0000040,
      ST_BDRAIN  = 28'h0000080,
      ST_MTOP    = 28'h0000100,
      ST_MCHK    = 28'h0000200,
      ST_MDF     = 28'h0000400,
      ST_ADV     = 28'h0000800,
      ST_ADRAIN  = 28'h0001000,
      ST_RL1     = 28'h0002000,
      ST_RL2     = 28'h0004000,
      ST_RLSCAN  = 28'h0008000,
      ST_RLDRAIN = 28'h0010000,
      ST_RL3     = 28'h0020000,
      ST_RL4     = 28'h0040000,
      ST_RL5     = 28'h0080000,
      ST_B1      = 28'h0100000,
      ST_B2      = 28'h0200000,
      ST_B3      = 28'h0400000,
      ST_U1      = 28'h0800000,
      ST_U2      = 28'h1000000,
      ST_U3      = 28'h2000000,
      ST_U4      = 28'h4000000,
      ST_DONE    = 28'h8000000
   } state_type;

   // controller to datapath
   typedef struct packed {
      state_type phase;
      logic      accept;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic bad_run;
      logic init_last;
      logic head_eq_end;
      logic head_eq_tail;
      logic scan_last;
      logic adv_hit;
      logic label_out;
      logic f_is_t;
      logic walk_is_s;
      logic gap_zero;
      logic clear_last;
      logic rsp_free;
   } status_type;

endpackage

// ===== rtl/mfi_ram.sv =====
// mfi_ram: generic simple dual-port RAM, one write and one registered read
// no dependencies
module mfi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mfi_ctrl.sv =====
// mfi_ctrl: sequencer of the max-flow engine (clear sweep, labeling
// search, advance/retreat/relabel, augment); uses mfi_pkg
module mfi_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic [mfi_pkg::CMD_W-1:0]     req_tuser,
   output logic                          req_tready,
   input  mfi_pkg::status_type           status,
   output mfi_pkg::cmd_type              cmd
);
   import mfi_pkg::*;

   state_type state_ff, state_in;

   // request side handshake
   assign req_tready = (state_ff == ST_IDLE);
   assign cmd.phase  = state_ff;
   assign cmd.accept = (state_ff == ST_IDLE) && req_tvalid;

   // next phase
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:   if (status.clear_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_RUN:   state_in = status.bad_run ? ST_DONE : ST_INIT;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_INIT:    if (status.init_last) state_in = ST_BSEED;
         ST_BSEED:   state_in = ST_BHEAD;
         ST_BHEAD: begin
            if (status.head_eq_end) begin
               state_in = status.head_eq_tail ? ST_MTOP : ST_BHEAD;
            end else begin
               state_in = ST_BQ;
            end
         end
         ST_BQ:      state_in = ST_BSCAN;
         ST_BSCAN:   if (status.scan_last) state_in = ST_BDRAIN;
         ST_BDRAIN:  state_in = ST_BHEAD;
         ST_MTOP:    state_in = ST_MCHK;
         ST_MCHK: begin
            if (status.label_out) state_in = ST_DONE;
            else if (status.f_is_t) state_in = ST_B1;
            else state_in = ST_MDF;
         end
         ST_MDF:     state_in = ST_ADV;
         ST_ADV: begin
            if (status.adv_hit) state_in = ST_MTOP;
            else if (status.scan_last) state_in = ST_ADRAIN;
         end
         ST_ADRAIN:  state_in = status.adv_hit ? ST_MTOP : ST_RL1;
         ST_RL1:     state_in = ST_RL2;
         ST_RL2:     state_in = status.gap_zero ? ST_DONE : ST_RLSCAN;
         ST_RLSCAN:  if (status.scan_last) state_in = ST_RLDRAIN;
         ST_RLDRAIN: state_in = ST_RL3;
         ST_RL3:     state_in = ST_RL4;
         ST_RL4:     state_in = ST_RL5;
         ST_RL5:     state_in = ST_MTOP;
         ST_B1:      state_in = status.walk_is_s ? ST_U1 : ST_B2;
         ST_B2:      state_in = ST_B3;
         ST_B3:      state_in = ST_B1;
         ST_U1:      state_in = status.walk_is_s ? ST_MTOP : ST_U2;
         ST_U2:      state_in = ST_U3;
         ST_U3:      state_in = ST_U4;
         ST_U4:      state_in = ST_U1;
         ST_DONE:    if (status.rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // phase register, reset starts the matrix clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/mfi_dp.sv =====
// mfi_dp: datapath of the max-flow engine: residual matrix and scratch
// memories, counters, labels, bottleneck and flow; uses mfi_pkg, mfi_ram
module mfi_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  mfi_pkg::cmd_type              cmd,
   input  logic [mfi_pkg::CMD_W-1:0]     req_cmd,
   input  logic [mfi_pkg::NODE_W-1:0]    req_from,
   input  logic [mfi_pkg::NODE_W-1:0]    req_to,
   input  logic [mfi_pkg::CAP_W-1:0]     req_cap,
   input  logic                          csr_we,
   input  logic [mfi_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [mfi_pkg::CSR_DW-1:0]    csr_wdata,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [mfi_pkg::FLOW_W-1:0]    rsp_flow,
   output mfi_pkg::status_type           status
);
   import mfi_pkg::*;

   // configuration registers
   logic [LABEL_W-1:0] node_count_ff;
   logic [NODE_W-1:0]  source_ff, sink_ff;

   // working registers
   logic [RM_AW-1:0]   clr_ff, clr_in;
   logic [LABEL_W-1:0] idx_ff, idx_in;
   logic [NODE_W-1:0]  u_ff, u_in;
   logic [LABEL_W-1:0] head_ff, head_in, tail_ff, tail_in, end_ff, end_in;
   logic [LABEL_W-1:0] level_ff, level_in, cnt_ff, cnt_in;
   logic [NODE_W-1:0]  f_ff, f_in, walk_ff, walk_in, prd_ff, prd_in, pj_ff;
   logic [LABEL_W-1:0] df_ff, df_in, low_ff, low_in;
   logic [RES_W-1:0]   bn_ff, bn_in;
   logic [FLOW_W-1:0]  flow_ff, flow_in, rsp_flow_ff, rsp_flow_in;
   logic               pvld_ff, pvld_in, rsp_tvalid_ff, rsp_tvalid_in;

   // memory ports
   logic               rm_we;
   logic [RM_AW-1:0]   rm_wa, rm_ra;
   logic [RES_W-1:0]   rm_wd, rm_rd;
   logic               dist_we;
   logic [NODE_W-1:0]  dist_wa, dist_ra;
   logic [LABEL_W-1:0] dist_wd, dist_rd;
   logic               gap_we;
   logic [GAP_AW-1:0]  gap_wa, gap_ra;
   logic [LABEL_W-1:0] gap_wd, gap_rd;
   logic               vis_we;
   logic [NODE_W-1:0]  vis_wa, vis_ra;
   logic               vis_wd, vis_rd;
   logic               q_we;
   logic [NODE_W-1:0]  q_wa, q_ra, q_wd, q_rd;
   logic               pr_we;
   logic [NODE_W-1:0]  pr_wa, pr_ra, pr_wd, pr_rd;

   logic [LABEL_W-1:0] n_w, low_inc;
   logic [FLOW_W:0]    flow_sum;
   logic               bfs_hit, adv_hit, low_hit, rsp_free;

   mfi_ram #(.WIDTH(RES_W), .DEPTH(RM_DEPTH)) u_rm (
      .clock(clock), .wr_en(rm_we), .wr_addr(rm_wa), .wr_data(rm_wd),
      .rd_addr(rm_ra), .rd_data(rm_rd));
   mfi_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_NODES)) u_dist (
      .clock(clock), .wr_en(dist_we), .wr_addr(dist_wa), .wr_data(dist_wd),
      .rd_addr(dist_ra), .rd_data(dist_rd));
   mfi_ram #(.WIDTH(LABEL_W), .DEPTH(GAP_DEPTH)) u_gap (
      .clock(clock), .wr_en(gap_we), .wr_addr(gap_wa), .wr_data(gap_wd),
      .rd_addr(gap_ra), .rd_data(gap_rd));
   mfi_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_vis (
      .clock(clock), .wr_en(vis_we), .wr_addr(vis_wa), .wr_data(vis_wd),
      .rd_addr(vis_ra), .rd_data(vis_rd));
   mfi_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(q_ra), .rd_data(q_rd));
   mfi_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_pred (
      .clock(clock), .wr_en(pr_we), .wr_addr(pr_wa), .wr_data(pr_wd),
      .rd_addr(pr_ra), .rd_data(pr_rd));

   // node count clipped to the matrix size
   assign n_w = (node_count_ff > LABEL_W'(MAX_NODES)) ? LABEL_W'(MAX_NODES)
                                                       : node_count_ff;
   assign low_inc = low_ff + 1'b1;

   // tests on the scan data returned in the cycle after issue
   assign bfs_hit = pvld_ff && (rm_rd != '0) && !vis_rd && !tail_ff[NODE_W];
   assign adv_hit = pvld_ff && (rm_rd != '0) &&
                    (({1'b0, dist_rd} + 1'b1) == {1'b0, df_ff});
   assign low_hit = pvld_ff && (rm_rd != '0) && (dist_rd < low_ff);

   assign rsp_free = !rsp_tvalid_ff || rsp_tready;
   assign flow_sum = {1'b0, flow_ff} + (FLOW_W + 1)'(bn_ff);

   // status to the controller
   assign status.bad_run      = ({1'b0, source_ff} >= n_w) || ({1'b0, sink_ff} >= n_w) ||
                                (source_ff == sink_ff);
   assign status.init_last    = (idx_ff == n_w + 1'b1);
   assign status.head_eq_end  = (head_ff == end_ff);
   assign status.head_eq_tail = (head_ff == tail_ff);
   assign status.scan_last    = (idx_ff == n_w - 1'b1);
   assign status.adv_hit      = adv_hit;
   assign status.label_out    = (dist_rd >= n_w);
   assign status.f_is_t       = (f_ff == sink_ff);
   assign status.walk_is_s    = (walk_ff == source_ff);
   assign status.gap_zero     = (gap_rd <= LABEL_W'(1));
   assign status.clear_last   = (clr_ff == {RM_AW{1'b1}});
   assign status.rsp_free     = rsp_free;

   // per-phase datapath operations
   always_comb begin
      rm_we = 1'b0;   rm_wa = {f_ff, idx_ff[NODE_W-1:0]};   rm_wd = '0;
      rm_ra = {f_ff, idx_ff[NODE_W-1:0]};
      dist_we = 1'b0; dist_wa = idx_ff[NODE_W-1:0]; dist_wd = n_w;
      dist_ra = idx_ff[NODE_W-1:0];
      gap_we = 1'b0;  gap_wa = idx_ff; gap_wd = '0; gap_ra = df_ff;
      vis_we = 1'b0;  vis_wa = idx_ff[NODE_W-1:0]; vis_wd = 1'b0;
      vis_ra = idx_ff[NODE_W-1:0];
      q_we = 1'b0;    q_wa = tail_ff[NODE_W-1:0]; q_wd = pj_ff;
      q_ra = head_ff[NODE_W-1:0];
      pr_we = 1'b0;   pr_wa = pj_ff; pr_wd = f_ff; pr_ra = walk_ff;

      clr_in = clr_ff;   idx_in = idx_ff;     u_in = u_ff;
      head_in = head_ff; tail_in = tail_ff;   end_in = end_ff;
      level_in = level_ff; cnt_in = cnt_ff;   f_in = f_ff;
      walk_in = walk_ff; prd_in = prd_ff;     df_in = df_ff;
      low_in = low_ff;   bn_in = bn_ff;       flow_in = flow_ff;
      rsp_flow_in = rsp_flow_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      pvld_in = (cmd.phase == ST_BSCAN) || (cmd.phase == ST_ADV) ||
                (cmd.phase == ST_RLSCAN);

      case (cmd.phase)
         // edge write or run start
         ST_IDLE: begin
            if (cmd.accept) begin
               case (req_cmd)
                  CMD_WRITE: begin
                     rm_we = 1'b1;
                     rm_wa = {req_from, req_to};
                     rm_wd = RES_W'(req_cap);
                  end
                  CMD_RUN: begin
                     flow_in = '0;
                     idx_in  = '0;
                  end
                  default: ;
               endcase
            end
         end
         // zero the residual matrix, one entry a cycle
         ST_CLEAR: begin
            rm_we  = 1'b1;
            rm_wa  = clr_ff;
            rm_wd  = '0;
            clr_in = clr_ff + 1'b1;
         end
         // scratch init: labels to n, counts and marks to zero
         ST_INIT: begin
            gap_we = 1'b1;
            if (idx_ff < n_w) begin
               dist_we = 1'b1;
               vis_we  = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
         end
         // seed the search queue with the sink
         ST_BSEED: begin
            q_we     = 1'b1;
            q_wa     = '0;
            q_wd     = sink_ff;
            vis_we   = 1'b1;
            vis_wa   = sink_ff;
            vis_wd   = 1'b1;
            head_in  = '0;
            tail_in  = LABEL_W'(1);
            end_in   = LABEL_W'(1);
            level_in = '0;
            cnt_in   = '0;
            f_in     = source_ff;
         end
         // close a level or pop the next node
         ST_BHEAD: begin
            if (head_ff == end_ff) begin
               gap_we   = 1'b1;
               gap_wa   = level_ff;
               gap_wd   = cnt_ff;
               level_in = level_ff + 1'b1;
               cnt_in   = '0;
               end_in   = tail_ff;
            end else begin
               head_in = head_ff + 1'b1;
            end
         end
         ST_BQ: begin
            u_in    = q_rd;
            dist_we = 1'b1;
            dist_wa = q_rd;
            dist_wd = level_ff;
            cnt_in  = cnt_ff + 1'b1;
            idx_in  = '0;
         end
         // scan column u for unvisited predecessors
         ST_BSCAN, ST_BDRAIN: begin
            if (cmd.phase == ST_BSCAN) begin
               rm_ra  = {idx_ff[NODE_W-1:0], u_ff};
               idx_in = idx_ff + 1'b1;
            end
            if (bfs_hit) begin
               q_we    = 1'b1;
               vis_we  = 1'b1;
               vis_wa  = pj_ff;
               vis_wd  = 1'b1;
               tail_in = tail_ff + 1'b1;
            end
         end
         // source label check, then label of the current node
         ST_MTOP: dist_ra = source_ff;
         ST_MCHK: begin
            dist_ra = f_ff;
            walk_in = sink_ff;
            bn_in   = '1;
         end
         ST_MDF: begin
            df_in  = dist_rd;
            idx_in = '0;
         end
         // find the first admissible edge out of f
         ST_ADV, ST_ADRAIN: begin
            if (cmd.phase == ST_ADV) begin
               idx_in = idx_ff + 1'b1;
            end
            if (adv_hit) begin
               pr_we = 1'b1;
               f_in  = pj_ff;
            end
         end
         // relabel: gap count of the old label
         ST_RL1: gap_ra = df_ff;
         ST_RL2: begin
            if (!status.gap_zero) begin
               gap_we = 1'b1;
               gap_wa = df_ff;
               gap_wd = gap_rd - 1'b1;
            end
            low_in = n_w;
            idx_in = '0;
         end
         ST_RLSCAN, ST_RLDRAIN: begin
            if (cmd.phase == ST_RLSCAN) begin
               idx_in = idx_ff + 1'b1;
            end
            if (low_hit) begin
               low_in = dist_rd;
            end
         end
         ST_RL3: begin
            dist_we = 1'b1;
            dist_wa = f_ff;
            dist_wd = low_inc;
            gap_ra  = low_inc;
         end
         ST_RL4: begin
            gap_we = 1'b1;
            gap_wa = low_inc;
            gap_wd = gap_rd + 1'b1;
            pr_ra  = f_ff;
         end
         // retreat one step
         ST_RL5: begin
            if (f_ff != source_ff) begin
               f_in = pr_rd;
            end
         end
         // bottleneck walk from the sink
         ST_B1: begin
            pr_ra = walk_ff;
            if (walk_ff == source_ff) begin
               walk_in = sink_ff;
            end
         end
         ST_B2, ST_U2: begin
            prd_in = pr_rd;
            rm_ra  = {pr_rd, walk_ff};
         end
         ST_B3: begin
            if (rm_rd < bn_ff) begin
               bn_in = rm_rd;
            end
            walk_in = prd_ff;
         end
         // update walk, then flow accumulate with saturation
         ST_U1: begin
            pr_ra = walk_ff;
            if (walk_ff == source_ff) begin
               flow_in = (flow_sum > {1'b0, FLOW_MAX}) ? FLOW_MAX
                                                        : flow_sum[FLOW_W-1:0];
               f_in    = source_ff;
            end
         end
         ST_U3: begin
            rm_we = 1'b1;
            rm_wa = {prd_ff, walk_ff};
            rm_wd = rm_rd - bn_ff;
            rm_ra = {walk_ff, prd_ff};
         end
         ST_U4: begin
            rm_we   = 1'b1;
            rm_wa   = {walk_ff, prd_ff};
            rm_wd   = rm_rd + bn_ff;
            walk_in = prd_ff;
         end
         // hand the result to the output register
         ST_DONE: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_flow_in   = flow_ff;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         pvld_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         node_count_ff <= LABEL_W'(MAX_NODES);
         source_ff     <= '0;
         sink_ff       <= NODE_W'(1);
      end else begin
         clr_ff        <= clr_in;
         pvld_ff       <= pvld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_NODE_COUNT: node_count_ff <= csr_wdata;
               CSR_SOURCE:     source_ff     <= csr_wdata[NODE_W-1:0];
               CSR_SINK:       sink_ff       <= csr_wdata[NODE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      u_ff        <= u_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      end_ff      <= end_in;
      level_ff    <= level_in;
      cnt_ff      <= cnt_in;
      f_ff        <= f_in;
      walk_ff     <= walk_in;
      prd_ff      <= prd_in;
      pj_ff       <= idx_ff[NODE_W-1:0];
      df_ff       <= df_in;
      low_ff      <= low_in;
      bn_ff       <= bn_in;
      flow_ff     <= flow_in;
      rsp_flow_ff <= rsp_flow_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_flow   = rsp_flow_ff;

endmodule

// ===== rtl/max_flow_isap_matrix_top.sv =====
// max_flow_isap_matrix_top: top level of the max-flow engine
// depends on mfi_pkg, mfi_ctrl, mfi_dp (and mfi_ram below it)
//
// Usage: the req channel carries one command per transfer, kind in tuser:
// edge write (capacity into matrix entry from,to), matrix clear, or run.
// Only a run produces a transfer on rsp, carrying the total flow.
// Edge writes can stream back to back.
// A clear sweeps the 4096-entry residual matrix at one entry per cycle,
// so the block takes no request until the sweep is over.
// A run does the scratch init and a seed step, then the labeling search,
// which scans the matrix column of each queued node and closes each
// level; then advance steps, each relabel with its failed scan, and for
// each augmented path a bottleneck walk and an update walk; the single
// read port of the residual matrix RAM makes these read it entry by entry.
// After a run the matrix holds residual capacities; reload or clear it.
// Reset runs the same clearing sweep of all 4096 entries with req_tready low;
// csr writes are taken at any time and node_count/source/sink reset to
// 64, 0 and 1. A stalled rsp holds its result in the output register;
// new requests are still taken, and a later run waits at its end.
module max_flow_isap_matrix_top (
   input  logic                          clock,
   input  logic                          reset,
   // requests
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mfi_pkg::REQ_W-1:0]     req_tdata,  // from_node, to_node, capacity
   input  logic [mfi_pkg::CMD_W-1:0]     req_tuser,  // cmd
   // results
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mfi_pkg::RSP_W-1:0]     rsp_tdata,  // total_flow
   // configuration
   input  logic                          csr_we,
   input  logic [mfi_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [mfi_pkg::CSR_DW-1:0]    csr_wdata
);
   import mfi_pkg::*;

   cmd_type            cmd;
   status_type         status;
   logic [FLOW_W-1:0]  rsp_flow;

   // controller
   mfi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath
   mfi_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_cmd    (req_tuser),
      .req_from   (req_tdata[NODE_W-1:0]),
      .req_to     (req_tdata[2*NODE_W-1:NODE_W]),
      .req_cap    (req_tdata[2*NODE_W+CAP_W-1:2*NODE_W]),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_flow   (rsp_flow),
      .status     (status)
   );

   assign rsp_tdata = RSP_W'(rsp_flow);

endmodule
